>>> src/sparse_table_range_min_max_top_assert.svh
// Assertion macros for the sparse table range min/max engine.
// Included by the checker; relies on signals named clock and reset in scope.
`ifndef SPARSE_TABLE_RANGE_MIN_MAX_TOP_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_MAX_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STRMM_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define STRMM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/strmm_pkg.sv
// Shared types and constants for the sparse table range min/max engine.
// No dependencies.
package strmm_pkg;

   localparam int DEPTH_DEF  = 1024;
   localparam int LEVELS_DEF = 11;

   localparam int POS_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RANGE = 2'd1,
      ST_NOT_BUILT = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_BREAD,
      S_BWRITE,
      S_RESP
   } fsm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic build_read;
      logic build_write;
      logic next_level;
      logic build_done;
      logic out_load;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_build;
      logic level_done;
      logic all_done;
   } dp_status_type;

endpackage

>>> src/strmm_ctrl.sv
// Controller state machine for the sparse table engine.
// Depends on strmm_pkg; drives datapath commands and the handshake control.
module strmm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  strmm_pkg::dp_status_type stat,
   output strmm_pkg::ctl_cmd_type   cmd
);
   import strmm_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = stat.start_build ? S_BREAD : S_RESP;
            end
         end
         S_BREAD: begin
            if (stat.all_done) begin
               state_in = S_RESP;
            end else if (!stat.level_done) begin
               state_in = S_BWRITE;
            end
         end
         S_BWRITE: state_in = S_BREAD;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:   cmd.accept = req_valid;
         S_BREAD: begin
            if (stat.all_done) begin
               cmd.build_done = 1'b1;
            end else if (stat.level_done) begin
               cmd.next_level = 1'b1;
            end else begin
               cmd.build_read = 1'b1;
            end
         end
         S_BWRITE: cmd.build_write = 1'b1;
         S_RESP:   cmd.out_load = out_free;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/strmm_datapath.sv
// Datapath of the sparse table engine: span memory, counters, query decode.
// Depends on strmm_pkg; commanded by strmm_ctrl.
module strmm_datapath #(
   parameter int DEPTH  = strmm_pkg::DEPTH_DEF,
   parameter int LEVELS = strmm_pkg::LEVELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  strmm_pkg::ctl_cmd_type                 cmd,
   output strmm_pkg::dp_status_type               stat,
   input  logic                                   req_kind,
   input  logic signed [strmm_pkg::VALUE_W-1:0]   req_value,
   input  logic                                   req_last_value,
   input  logic        [strmm_pkg::POS_W-1:0]     req_left,
   input  logic        [strmm_pkg::POS_W-1:0]     req_right,
   output logic signed [strmm_pkg::VALUE_W-1:0]   rsp_range_max,
   output logic signed [strmm_pkg::VALUE_W-1:0]   rsp_range_min,
   output logic        [strmm_pkg::STATUS_W-1:0]  rsp_status
);
   import strmm_pkg::*;

   localparam int PW        = $clog2(DEPTH);
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int AL        = $clog2(LEVELS);
   localparam int LVW       = $clog2(LEVELS + 1);
   localparam int AW        = AL + PW;
   localparam int MEM_DEPTH = LEVELS * (2 ** PW);
   localparam int QW0       = (POS_W > CW) ? POS_W : CW;
   localparam int QW        = ((QW0 > LEVELS) ? QW0 : LEVELS) + 1;
   localparam int EW        = 2 * VALUE_W;

   // entry layout: max in the upper half, min in the lower half
   function automatic logic [EW-1:0] merge(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic signed [VALUE_W-1:0] a_max, a_min, b_max, b_min, m_max, m_min;
      a_max = a[EW-1:VALUE_W];
      a_min = a[VALUE_W-1:0];
      b_max = b[EW-1:VALUE_W];
      b_min = b[VALUE_W-1:0];
      m_max = (a_max < b_max) ? b_max : a_max;
      m_min = (b_min < a_min) ? b_min : a_min;
      return {m_max, m_min};
   endfunction

   logic [EW-1:0] span_mem [MEM_DEPTH];
   logic [EW-1:0] rd0_ff, rd1_ff;

   logic [CW-1:0]  count_ff, count_in;
   logic           built_ff, built_in;
   logic [LVW-1:0] lvl_ff, lvl_in;
   logic [PW-1:0]  idx_ff, idx_in;
   status_type     status_ff, status_in;
   logic           query_ok_ff, query_ok_in;
   logic signed [VALUE_W-1:0] out_max_ff, out_min_ff;
   status_type     out_status_ff;

   logic [QW-1:0]  left_q, right_q, count_q, len, span, span_end;
   logic [AL-1:0]  k;
   logic [PW-1:0]  q_a, q_b;
   logic           bad_range, full, is_append;
   logic [LVW-1:0] lvl_prev;
   logic [PW-1:0]  half_pos;

   logic           we, re;
   logic [AW-1:0]  wa, ra0, ra1;
   logic [EW-1:0]  wd, combined;

   // query decode from the request ports
   always_comb begin
      left_q    = QW'(req_left);
      right_q   = QW'(req_right);
      count_q   = QW'(count_ff);
      bad_range = (left_q == '0) || (right_q > count_q) || (left_q > right_q);
      len       = right_q - left_q + QW'(1);
      k         = '0;
      for (int n = 1; n < LEVELS; n++) begin
         if ((len >> n) != '0) begin
            k = AL'(n);
         end
      end
      q_a = PW'(left_q - QW'(1));
      q_b = PW'(right_q - (QW'(1) << k));
   end

   assign is_append = (req_kind == KIND_APPEND);
   assign full      = (count_ff == CW'(DEPTH));

   // build walk
   assign lvl_prev = lvl_ff - LVW'(1);
   assign span     = QW'(1) << lvl_ff;
   assign span_end = QW'(idx_ff) + span;
   assign half_pos = idx_ff + PW'(QW'(1) << lvl_prev);

   assign stat.start_build = is_append && !full && req_last_value;
   assign stat.level_done  = (span_end > count_q);
   assign stat.all_done    = (lvl_ff == LVW'(LEVELS)) || (span > count_q);

   assign combined = merge(rd0_ff, rd1_ff);

   // memory port steering
   always_comb begin
      we  = 1'b0;
      wa  = {AL'(0), count_ff[PW-1:0]};
      wd  = {req_value, req_value};
      re  = 1'b0;
      ra0 = {k, q_a};
      ra1 = {k, q_b};
      if (cmd.accept) begin
         we = is_append && !full;
         re = !is_append;
      end
      if (cmd.build_read) begin
         re  = 1'b1;
         ra0 = {lvl_prev[AL-1:0], idx_ff};
         ra1 = {lvl_prev[AL-1:0], half_pos};
      end
      if (cmd.build_write) begin
         we = 1'b1;
         wa = {lvl_ff[AL-1:0], idx_ff};
         wd = combined;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         span_mem[wa] <= wd;
      end
      if (re) begin
         rd0_ff <= span_mem[ra0];
         rd1_ff <= span_mem[ra1];
      end
   end

   // control state and request bookkeeping
   always_comb begin
      count_in    = count_ff;
      built_in    = built_ff;
      lvl_in      = lvl_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      query_ok_in = query_ok_ff;
      if (cmd.accept) begin
         if (is_append) begin
            status_in   = full ? ST_FULL : ST_OK;
            query_ok_in = 1'b0;
            if (!full) begin
               count_in = count_ff + CW'(1);
               built_in = 1'b0;
            end
            lvl_in = LVW'(1);
            idx_in = '0;
         end else begin
            if (!built_ff) begin
               status_in = ST_NOT_BUILT;
            end else if (bad_range) begin
               status_in = ST_BAD_RANGE;
            end else begin
               status_in = ST_OK;
            end
            query_ok_in = built_ff && !bad_range;
         end
      end
      if (cmd.next_level) begin
         lvl_in = lvl_ff + LVW'(1);
         idx_in = '0;
      end
      if (cmd.build_write) begin
         idx_in = idx_ff + PW'(1);
      end
      if (cmd.build_done) begin
         built_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         built_ff    <= 1'b0;
         lvl_ff      <= LVW'(1);
         idx_ff      <= '0;
         status_ff   <= ST_OK;
         query_ok_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         built_ff    <= built_in;
         lvl_ff      <= lvl_in;
         idx_ff      <= idx_in;
         status_ff   <= status_in;
         query_ok_ff <= query_ok_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= status_ff;
         out_max_ff    <= query_ok_ff ? combined[EW-1:VALUE_W] : '0;
         out_min_ff    <= query_ok_ff ? combined[VALUE_W-1:0] : '0;
      end
   end

   assign rsp_range_max = out_max_ff;
   assign rsp_range_min = out_min_ff;
   assign rsp_status    = out_status_ff;

endmodule

>>> src/sparse_table_range_min_max_top.sv
// Top level of the sparse table range min/max engine.
// Depends on strmm_pkg, strmm_ctrl and strmm_datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_stall    kind, value, last_value, left, right
//   rsp_      out        rsp_valid/rsp_stall    range_max, range_min, status
//
// Query or append: the accept read or write, then the result register load.
// An append marked last then builds: for each of the N-2^j+1 spans of level j it
// reads a pair, then merges and writes; a level step ends each level, and a closing
// step marks the table built after the last level.
// Reset clears only counters, flags and the FSM; the table memory is not reset.
// A stalled result holds in the output register while the next request is taken.
module sparse_table_range_min_max_top #(
   parameter int DEPTH  = strmm_pkg::DEPTH_DEF,
   parameter int LEVELS = strmm_pkg::LEVELS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic signed [strmm_pkg::VALUE_W-1:0]   req_value,
   input  logic                                   req_last_value,
   input  logic        [strmm_pkg::POS_W-1:0]     req_left,
   input  logic        [strmm_pkg::POS_W-1:0]     req_right,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [strmm_pkg::VALUE_W-1:0]   rsp_range_max,
   output logic signed [strmm_pkg::VALUE_W-1:0]   rsp_range_min,
   output logic        [strmm_pkg::STATUS_W-1:0]  rsp_status
);
   import strmm_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type stat;

   // sequencing: accept, build walk, result hand-off
   strmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table memory, item count, built flag and result register
   strmm_datapath #(
      .DEPTH  (DEPTH),
      .LEVELS (LEVELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_last_value (req_last_value),
      .req_left       (req_left),
      .req_right      (req_right),
      .rsp_range_max  (rsp_range_max),
      .rsp_range_min  (rsp_range_min),
      .rsp_status     (rsp_status)
   );

endmodule

>>> src/strmm_checker.sv
// Port-level assertions for the sparse table engine, bound to the top level.
// Depends on strmm_pkg and sparse_table_range_min_max_top_assert.svh.
`include "sparse_table_range_min_max_top_assert.svh"

module strmm_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [strmm_pkg::VALUE_W-1:0]   rsp_range_max,
   input logic signed [strmm_pkg::VALUE_W-1:0]   rsp_range_min,
   input logic        [strmm_pkg::STATUS_W-1:0]  rsp_status
);
   import strmm_pkg::*;

   // hold a stalled result
   `STRMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_range_max) && $stable(rsp_range_min) && $stable(rsp_status), "stalled response changed")

   // values are zero unless the status is ok
   `STRMM_ASSERT_IMPLY(a_err_zero, rsp_valid && (rsp_status != ST_OK), (rsp_range_max == '0) && (rsp_range_min == '0), "nonzero values with error status")

   // an ok result never has max below min
   `STRMM_ASSERT_IMPLY(a_order, rsp_valid && (rsp_status == ST_OK), rsp_range_max >= rsp_range_min, "range max below range min")

   // busy in the cycle after a request is taken
   `STRMM_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall, "request taken back to back")

endmodule

bind sparse_table_range_min_max_top strmm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_range_max (rsp_range_max),
   .rsp_range_min (rsp_range_min),
   .rsp_status    (rsp_status)
);
